[sv/rssh_pkg.sv]
package rssh_pkg;

    localparam int NUM_COLUMNS        = 4;
    localparam int NUM_ROWS           = 4;
    localparam int SAMPLE_BITS        = 16;
    localparam int SLEW_STEPS_DEFAULT = 100;
    localparam int LEVEL_BITS         = 7;
    localparam int ROW_BITS           = $clog2(NUM_ROWS);
    localparam int ROWS_CFG_BITS      = 3;
    localparam int CFG_IDX_BITS       = 2;
    localparam int CFG_DATA_BITS      = 16;
    localparam int PIPE_STAGES        = 4;
    localparam int MOD_STEPS          = (NUM_ROWS + 1) / 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [NUM_ROWS-1:0][LEVEL_BITS-1:0] t_level_vec;

    localparam t_sample PREV_RESET       = -16'sd2048;
    localparam t_sample CLOCK_HIGH_RESET = 16'sd4096;
    localparam t_sample CLOCK_LOW_RESET  = 16'sd0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROWS_IN_USE,
        CFG_CLOCK_HIGH,
        CFG_CLOCK_LOW
    } t_cfg_reg;

    typedef struct packed {
        logic                  fire;
        logic                  adv;
        logic [LEVEL_BITS-1:0] level;
    } t_lane_ctl;

    typedef struct packed {
        logic                valid;
        logic [ROW_BITS-1:0] row;
        t_level_vec          levels;
    } t_tick;

endpackage

[sv/rssh_if.sv]
interface rssh_in_if import rssh_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample cv_in_0;
    t_sample cv_in_1;
    t_sample cv_in_2;
    t_sample cv_in_3;
    t_sample clock_cv;
    logic    next_press;
    logic    prev_press;

    modport source (
        output valid, cv_in_0, cv_in_1, cv_in_2, cv_in_3, clock_cv, next_press, prev_press,
        input  ready
    );
    modport sink (
        input  valid, cv_in_0, cv_in_1, cv_in_2, cv_in_3, clock_cv, next_press, prev_press,
        output ready
    );
endinterface

interface rssh_out_if import rssh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ROW_BITS-1:0]   row_index;
    t_sample               held_0;
    t_sample               held_1;
    t_sample               held_2;
    t_sample               held_3;
    logic [LEVEL_BITS-1:0] row_level;
    logic                  row_active;
    logic                  last_of_tick;

    modport source (
        output valid, row_index, held_0, held_1, held_2, held_3, row_level, row_active,
               last_of_tick,
        input  ready
    );
    modport sink (
        input  valid, row_index, held_0, held_1, held_2, held_3, row_level, row_active,
               last_of_tick,
        output ready
    );
endinterface

interface rssh_cfg_if import rssh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/rssh_lane.sv]
module rssh_lane import rssh_pkg::*; #(
    parameter int SLEW_STEPS = SLEW_STEPS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_cv,
    output t_sample   o_held,
    output logic      o_chg
);

    localparam int PW = SAMPLE_BITS + LEVEL_BITS + 1;
    localparam int AW = SAMPLE_BITS + LEVEL_BITS;
    localparam int MW = 2 * AW + 1;
    localparam logic [AW:0]   RECIP   = (AW + 1)'((2 ** AW) / SLEW_STEPS);
    localparam logic [AW-1:0] STEPS_V = AW'(SLEW_STEPS);

    t_sample              r_prev;
    t_sample              r_x;
    logic                 r_chg0;
    logic                 r_chg1;
    logic                 r_chg2;
    logic                 r_chg3;
    logic signed [PW-1:0] r_p;
    logic [AW-1:0]        r_abs2;
    logic [AW-1:0]        r_abs3;
    logic [AW-1:0]        r_q3;
    logic                 r_neg2;
    logic                 r_neg3;
    logic signed [PW-1:0] w_prod;
    logic [MW-1:0]        w_mul;
    logic [AW-1:0]        w_rem;
    logic [AW-1:0]        w_q;
    logic [AW-1:0]        w_signed_q;

    assign w_prod = PW'(r_x) * PW'($signed({1'b0, i_ctl.level}));
    assign w_mul  = MW'(r_abs2) * MW'(RECIP);

    // The reciprocal estimate is low by at most one, so one compare corrects it.
    assign w_rem      = r_abs3 - r_q3 * STEPS_V;
    assign w_q        = r_q3 + AW'(w_rem >= STEPS_V);
    assign w_signed_q = r_neg3 ? AW'(0) - w_q : w_q;
    assign o_held     = w_signed_q[SAMPLE_BITS-1:0];
    assign o_chg      = r_chg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= PREV_RESET;
            r_chg0 <= 1'b0;
            r_chg1 <= 1'b0;
            r_chg2 <= 1'b0;
            r_chg3 <= 1'b0;
        end else begin
            if (i_ctl.fire) begin
                r_prev <= i_cv;
            end
            if (i_ctl.adv) begin
                r_chg0 <= i_ctl.fire && (i_cv != r_prev);
                r_chg1 <= r_chg0;
                r_chg2 <= r_chg1;
                r_chg3 <= r_chg2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_x    <= i_cv;
            r_p    <= w_prod;
            r_neg2 <= r_p[PW-1];
            r_abs2 <= AW'(r_p[PW-1] ? -r_p : r_p);
            r_neg3 <= r_neg2;
            r_abs3 <= r_abs2;
            r_q3   <= w_mul[AW +: AW];
        end
    end

endmodule

[sv/rssh_ctrl.sv]
module rssh_ctrl import rssh_pkg::*; #(
    parameter int SLEW_STEPS = SLEW_STEPS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_fire,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  t_sample                  i_clock_cv,
    input  logic                     i_next,
    input  logic                     i_prev,
    input  logic                     i_emit_ready,
    output logic                     o_in_ready,
    output t_lane_ctl                o_lane,
    output t_tick                    o_tick
);

    localparam int SUM_W = ROW_BITS + 2;
    localparam int MOD_W = ROW_BITS + 1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(SLEW_STEPS);

    logic [ROWS_CFG_BITS-1:0] r_rows;
    t_sample                  r_hi;
    t_sample                  r_lo;
    logic [ROW_BITS-1:0]      r_active;
    logic                     r_clk_hi;
    logic                     r_next_hi;
    logic                     r_prev_hi;
    t_level_vec               r_slew;
    logic [PIPE_STAGES-1:0]   r_vld;
    logic [ROW_BITS-1:0]      r_row [PIPE_STAGES];
    t_level_vec               r_lvl [PIPE_STAGES];

    logic                     w_adv;
    logic                     w_fire;
    logic                     w_clk_edge;
    logic                     n_clk_hi;
    logic                     w_next_edge;
    logic                     w_prev_edge;
    logic [MOD_W-1:0]         w_rows;
    logic signed [SUM_W-1:0]  w_sum;
    logic [MOD_W-1:0]         w_mod;
    logic [ROW_BITS-1:0]      n_active;
    t_level_vec               n_slew;

    assign w_adv      = !r_vld[PIPE_STAGES-1] || i_emit_ready;
    assign w_fire     = i_in_valid && w_adv;
    assign o_in_ready = w_adv;

    assign o_lane.fire  = w_fire;
    assign o_lane.adv   = w_adv;
    assign o_lane.level = r_lvl[0][r_row[0]];

    assign o_tick.valid  = r_vld[PIPE_STAGES-1];
    assign o_tick.row    = r_row[PIPE_STAGES-1];
    assign o_tick.levels = r_lvl[PIPE_STAGES-1];

    always_comb begin
        if (r_rows < ROWS_CFG_BITS'(2)) begin
            w_rows = MOD_W'(2);
        end else if (r_rows > ROWS_CFG_BITS'(NUM_ROWS)) begin
            w_rows = MOD_W'(NUM_ROWS);
        end else begin
            w_rows = MOD_W'(r_rows);
        end
    end

    // The clock trigger looks only at the threshold on the far side of its state.
    always_comb begin
        n_clk_hi   = r_clk_hi;
        w_clk_edge = 1'b0;
        if (r_clk_hi) begin
            if (i_clock_cv <= r_lo) begin
                n_clk_hi = 1'b0;
            end
        end else if (i_clock_cv >= r_hi) begin
            n_clk_hi   = 1'b1;
            w_clk_edge = 1'b1;
        end
    end

    assign w_next_edge = i_next && !r_next_hi;
    assign w_prev_edge = i_prev && !r_prev_hi;
    assign w_sum = SUM_W'(r_active) + SUM_W'(w_clk_edge) + SUM_W'(w_next_edge)
                 - SUM_W'(w_prev_edge);

    always_comb begin
        w_mod = w_sum[MOD_W-1:0];
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (w_mod >= w_rows) begin
                w_mod = w_mod - w_rows;
            end
        end
        if (w_sum[SUM_W-1]) begin
            n_active = ROW_BITS'(w_rows - 1'b1);
        end else begin
            n_active = w_mod[ROW_BITS-1:0];
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (ROW_BITS'(r) == n_active) begin
                n_slew[r] = (r_slew[r] < LEVEL_MAX) ? r_slew[r] + 1'b1 : LEVEL_MAX;
            end else begin
                n_slew[r] = (r_slew[r] != '0) ? r_slew[r] - 1'b1 : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= ROWS_CFG_BITS'(NUM_ROWS);
            r_hi      <= CLOCK_HIGH_RESET;
            r_lo      <= CLOCK_LOW_RESET;
            r_active  <= '0;
            r_clk_hi  <= 1'b0;
            r_next_hi <= 1'b0;
            r_prev_hi <= 1'b0;
            r_slew    <= '0;
            r_vld     <= '0;
        end else begin
            if (i_cfg_fire) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_ROWS_IN_USE: r_rows <= i_cfg_data[ROWS_CFG_BITS-1:0];
                    CFG_CLOCK_HIGH:  r_hi   <= i_cfg_data;
                    CFG_CLOCK_LOW:   r_lo   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_fire) begin
                r_active  <= n_active;
                r_clk_hi  <= n_clk_hi;
                r_next_hi <= i_next;
                r_prev_hi <= i_prev;
                r_slew    <= n_slew;
            end
            if (w_adv) begin
                r_vld <= {r_vld[PIPE_STAGES-2:0], w_fire};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row[0] <= n_active;
            r_lvl[0] <= n_slew;
            for (int k = 1; k < PIPE_STAGES; k++) begin
                r_row[k] <= r_row[k-1];
                r_lvl[k] <= r_lvl[k-1];
            end
        end
    end

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (MOD_W'(r_active) < $past(w_rows)))
        else $error("active row left the rows in use");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_STAGES-1] && !i_emit_ready
        |=> r_vld[PIPE_STAGES-1] && $stable(r_row[PIPE_STAGES-1]))
        else $error("finished tick lost while the result side was busy");

endmodule

[sv/rssh_emit.sv]
module rssh_emit import rssh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tick                  i_tick,
    input  t_sample                i_held [NUM_COLUMNS],
    input  logic [NUM_COLUMNS-1:0] i_chg,
    output logic                   o_ready,
    rssh_out_if.source             o_out
);

    t_sample             r_bank [NUM_ROWS][NUM_COLUMNS];
    logic                r_busy;
    logic [ROW_BITS-1:0] r_cnt;
    logic [ROW_BITS-1:0] r_act;
    t_level_vec          r_lvls;
    logic                w_last;
    logic                w_out_fire;
    logic                w_load;

    assign w_last     = r_cnt == ROW_BITS'(NUM_ROWS - 1);
    assign w_out_fire = r_busy && o_out.ready;
    assign o_ready    = !r_busy || (w_out_fire && w_last);
    assign w_load     = i_tick.valid && o_ready;

    assign o_out.valid        = r_busy;
    assign o_out.row_index    = r_cnt;
    assign o_out.held_0       = r_bank[r_cnt][0];
    assign o_out.held_1       = r_bank[r_cnt][1];
    assign o_out.held_2       = r_bank[r_cnt][2];
    assign o_out.held_3       = r_bank[r_cnt][3];
    assign o_out.row_level    = r_lvls[r_cnt];
    assign o_out.row_active   = r_cnt == r_act;
    assign o_out.last_of_tick = w_last;

    // The held store changes only when a new tick is loaded, after the last row has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_COLUMNS; c++) begin
                    r_bank[r][c] <= '0;
                end
            end
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                if (i_chg[c]) begin
                    r_bank[i_tick.row][c] <= i_held[c];
                end
            end
        end else if (w_out_fire) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_act  <= i_tick.row;
            r_lvls <= i_tick.levels;
        end
    end

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_busy && (r_cnt == '0))
        else $error("loaded tick does not start at the first row");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && !w_last |=> r_busy && (r_cnt == $past(r_cnt) + 1'b1))
        else $error("row sequence skipped or repeated a row");

endmodule

[sv/row_select_sample_hold_matrix.sv]
// Row-select sample-and-hold matrix. Each input word is one control tick: four column voltages,
// a clock voltage and the next and previous button levels. A Schmitt-triggered clock edge or a
// next press moves the active row forward, a previous press moves it back, and the active row
// samples every column whose input changed, scaled by its slewed level. Each tick produces four
// output words, one per row from row 0 upward, with last_of_tick set on the final one. A tick
// passes through a four-stage pipeline of per-column scaling lanes (multiply by the level, then a
// reciprocal multiply for the division) before its output words are sent. The output stage
// sends one row per cycle while the receiver is ready, and new ticks are taken while the rows
// of earlier ones are still being sent. The configuration port is always ready; the user must
// write it only while the block is idle, which the block itself does not enforce.
module row_select_sample_hold_matrix import rssh_pkg::*; #(
    parameter int SLEW_STEPS = SLEW_STEPS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rssh_in_if.sink    i_in,
    rssh_out_if.source o_out,
    rssh_cfg_if.sink   i_cfg
);

    t_sample                w_cv   [NUM_COLUMNS];
    t_sample                w_held [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] w_chg;
    t_lane_ctl              w_lane;
    t_tick                  w_tick;
    logic                   w_emit_ready;

    assign w_cv[0] = i_in.cv_in_0;
    assign w_cv[1] = i_in.cv_in_1;
    assign w_cv[2] = i_in.cv_in_2;
    assign w_cv[3] = i_in.cv_in_3;

    assign i_cfg.ready = 1'b1;

    rssh_ctrl #(
        .SLEW_STEPS (SLEW_STEPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_fire   (i_cfg.valid && i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_in_valid   (i_in.valid),
        .i_clock_cv   (i_in.clock_cv),
        .i_next       (i_in.next_press),
        .i_prev       (i_in.prev_press),
        .i_emit_ready (w_emit_ready),
        .o_in_ready   (i_in.ready),
        .o_lane       (w_lane),
        .o_tick       (w_tick)
    );

    for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_lane
        rssh_lane #(
            .SLEW_STEPS (SLEW_STEPS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_lane),
            .i_cv    (w_cv[c]),
            .o_held  (w_held[c]),
            .o_chg   (w_chg[c])
        );
    end

    rssh_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_held  (w_held),
        .i_chg   (w_chg),
        .o_ready (w_emit_ready),
        .o_out   (o_out)
    );

endmodule

[tb/row_select_sample_hold_matrix_test.sv]
`timescale 1ns / 1ps

module row_select_sample_hold_matrix_test;
    import rssh_pkg::*;

    typedef struct {
        t_sample cv[NUM_COLUMNS];
        t_sample clock_cv;
        logic    next_press;
        logic    prev_press;
    } t_tick_word;

    typedef struct {
        logic [ROW_BITS-1:0]   row;
        t_sample               held[NUM_COLUMNS];
        logic [LEVEL_BITS-1:0] level;
        logic                  active;
        logic                  last;
    } t_row_word;

    class row_hold_board;
        logic [ROWS_CFG_BITS-1:0] rows_cfg;
        t_sample                  clk_high;
        t_sample                  clk_low;
        int                       active_row;
        bit                       clk_trig;
        bit                       next_trig;
        bit                       prev_trig;
        t_sample                  last_cv[NUM_COLUMNS];
        t_sample                  held[NUM_ROWS][NUM_COLUMNS];
        int                       level[NUM_ROWS];
        t_row_word                pending_row_words[$];
        int                       mismatches;
        int                       ticks_taken;
        int                       words_checked;

        function new();
            rows_cfg   = 3'd4;
            clk_high   = CLOCK_HIGH_RESET;
            clk_low    = CLOCK_LOW_RESET;
            active_row = 0;
            clk_trig   = 1'b0;
            next_trig  = 1'b0;
            prev_trig  = 1'b0;
            foreach (last_cv[c]) last_cv[c] = PREV_RESET;
            foreach (held[r, c]) held[r][c] = '0;
            foreach (level[r]) level[r] = 0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [CFG_DATA_BITS-1:0] d);
            case (r)
                CFG_ROWS_IN_USE: rows_cfg = d[ROWS_CFG_BITS-1:0];
                CFG_CLOCK_HIGH:  clk_high = t_sample'(d);
                CFG_CLOCK_LOW:   clk_low  = t_sample'(d);
                default: ;
            endcase
        endfunction

        // A high trigger only looks at the low threshold and a low one only at the high.
        function bit rising(inout bit trig, input int x, input int hi, input int lo);
            if (trig) begin
                if (x <= lo) trig = 1'b0;
                return 1'b0;
            end
            if (x >= hi) begin
                trig = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_tick(t_tick_word t);
            int                     rows;
            int                     row;
            bit [NUM_COLUMNS-1:0]   changed;
            t_row_word              w;
            rows = rows_cfg;
            if (rows < 2) rows = 2;
            if (rows > NUM_ROWS) rows = NUM_ROWS;
            row = active_row;
            if (rising(clk_trig, t.clock_cv, clk_high, clk_low)) row++;
            if (rising(next_trig, t.next_press, 1, 0)) row++;
            if (rising(prev_trig, t.prev_press, 1, 0)) row--;
            if (row < 0) row = rows - 1;
            row = row % rows;
            active_row = row;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                changed[c] = (t.cv[c] != last_cv[c]);
                last_cv[c] = t.cv[c];
            end
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (r == row) begin
                    if (level[r] < SLEW_STEPS_DEFAULT) level[r]++;
                end else if (level[r] > 0) begin
                    level[r]--;
                end
            end
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                if (changed[c]) begin
                    held[row][c] = t_sample'((int'(t.cv[c]) * level[row]) / SLEW_STEPS_DEFAULT);
                end
            end
            for (int r = 0; r < NUM_ROWS; r++) begin
                w.row = ROW_BITS'(r);
                foreach (w.held[c]) w.held[c] = held[r][c];
                w.level  = LEVEL_BITS'(level[r]);
                w.active = (r == row);
                w.last   = (r == NUM_ROWS - 1);
                pending_row_words.push_back(w);
            end
            ticks_taken++;
        endfunction

        function void compare(string field, longint want, longint seen);
            if (want != seen) begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_row_word(t_row_word got);
            t_row_word want;
            if (pending_row_words.size() == 0) begin
                $error("row_index: expected no word, got %0d", got.row);
                mismatches++;
                return;
            end
            want = pending_row_words.pop_front();
            compare("row_index", want.row, got.row);
            foreach (want.held[c]) compare($sformatf("held_%0d", c), want.held[c], got.held[c]);
            compare("row_level", want.level, got.level);
            compare("row_active", want.active, got.active);
            compare("last_of_tick", want.last, got.last);
            words_checked++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rssh_in_if  in_bus ();
    rssh_out_if out_bus ();
    rssh_cfg_if cfg_bus ();

    row_select_sample_hold_matrix u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    row_hold_board board = new();
    t_tick_word    last_tick;
    bit            sender_calm;
    int            settings_used = 1;

    t_tick_word plan[20] = '{
        '{'{-2048, -2048, -2048, -2048}, 0, 1'b0, 1'b0},
        '{'{32767, -32768, 0, -1}, 4095, 1'b0, 1'b0},
        '{'{32767, -32768, 0, -1}, 4096, 1'b0, 1'b0},
        '{'{-32768, 32767, -1, 0}, 4096, 1'b1, 1'b0},
        '{'{-32768, 32767, -1, 0}, 1, 1'b1, 1'b1},
        '{'{1, -1, 32767, -32768}, 0, 1'b0, 1'b0},
        '{'{1, -1, 32767, -32768}, 32767, 1'b1, 1'b0},
        '{'{1, -1, 32767, -32768}, -32768, 1'b0, 1'b0},
        '{'{0, 0, 0, 0}, -32768, 1'b0, 1'b1},
        '{'{0, 0, 0, 0}, 0, 1'b0, 1'b0},
        '{'{-1, 1, -32768, 32767}, 0, 1'b0, 1'b1},
        '{'{-1, 1, -32768, 32767}, 0, 1'b0, 1'b0},
        '{'{32767, 32767, 32767, 32767}, 0, 1'b0, 1'b1},
        '{'{32767, 32767, 32767, 32767}, 0, 1'b0, 1'b0},
        '{'{-32768, -32768, -32768, -32768}, 0, 1'b0, 1'b1},
        '{'{-32768, -32768, -32768, -32768}, 4096, 1'b1, 1'b0},
        '{'{21845, -21846, 10922, -10923}, -1, 1'b0, 1'b0},
        '{'{21845, -21846, 10922, -10923}, 5000, 1'b1, 1'b1},
        '{'{32767, 32767, -32768, -32768}, 0, 1'b0, 1'b0},
        '{'{-2048, -2048, -2048, -2048}, 0, 1'b0, 1'b0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_tick(input t_tick_word t);
        int gap;
        if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.cv_in_0    <= t.cv[0];
        in_bus.cv_in_1    <= t.cv[1];
        in_bus.cv_in_2    <= t.cv[2];
        in_bus.cv_in_3    <= t.cv[3];
        in_bus.clock_cv   <= t.clock_cv;
        in_bus.next_press <= t.next_press;
        in_bus.prev_press <= t.prev_press;
        in_bus.valid      <= 1'b1;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        board.take_tick(t);
        last_tick = t;
    endtask

    function automatic t_tick_word random_tick(input bit steady);
        t_tick_word t;
        t = last_tick;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            case ($urandom_range(0, 5))
                0, 1: ;
                2: begin
                    case ($urandom_range(0, 4))
                        0: t.cv[c] = 16'sd32767;
                        1: t.cv[c] = -16'sd32768;
                        2: t.cv[c] = 16'sd0;
                        3: t.cv[c] = -16'sd1;
                        default: t.cv[c] = PREV_RESET;
                    endcase
                end
                default: t.cv[c] = t_sample'($urandom);
            endcase
        end
        if (steady) begin
            t.clock_cv   = board.clk_low;
            t.next_press = 1'b0;
            t.prev_press = 1'b0;
        end else begin
            case ($urandom_range(0, 7))
                0: t.clock_cv = board.clk_high;
                1: t.clock_cv = board.clk_high - 16'sd1;
                2: t.clock_cv = board.clk_low;
                3: t.clock_cv = board.clk_low + 16'sd1;
                4: t.clock_cv = 16'sd32767;
                5: t.clock_cv = -16'sd32768;
                default: t.clock_cv = t_sample'($urandom);
            endcase
            if ($urandom_range(0, 2) == 0) t.next_press = !t.next_press;
            if ($urandom_range(0, 2) == 0) t.prev_press = !t.prev_press;
        end
        return t;
    endfunction

    task automatic wait_drained();
        while (board.pending_row_words.size() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg r, input logic [CFG_DATA_BITS-1:0] d);
        cfg_bus.index <= r;
        cfg_bus.data  <= d;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        board.set_reg(r, d);
    endtask

    task automatic run_phase(input logic [ROWS_CFG_BITS-1:0] rows, input t_sample hi,
                             input t_sample lo, input int count, input bit steady);
        logic [CFG_DATA_BITS-1:0] rows_word;
        wait_drained();
        rows_word = CFG_DATA_BITS'($urandom);
        rows_word[ROWS_CFG_BITS-1:0] = rows;
        cfg_write(CFG_ROWS_IN_USE, rows_word);
        cfg_write(CFG_CLOCK_HIGH, hi);
        cfg_write(CFG_CLOCK_LOW, lo);
        cfg_bus.valid <= 1'b0;
        settings_used++;
        repeat (count) send_tick(random_tick(steady));
        in_bus.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.cv_in_0    = '0;
        in_bus.cv_in_1    = '0;
        in_bus.cv_in_2    = '0;
        in_bus.cv_in_3    = '0;
        in_bus.clock_cv   = '0;
        in_bus.next_press = 1'b0;
        in_bus.prev_press = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_ROWS_IN_USE;
        cfg_bus.data      = '0;
        foreach (last_tick.cv[c]) last_tick.cv[c] = PREV_RESET;
        last_tick.clock_cv   = '0;
        last_tick.next_press = 1'b0;
        last_tick.prev_press = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_tick(plan[k]);
        in_bus.valid <= 1'b0;

        // The held row lets its level climb to full scale before the selector moves again.
        run_phase(3'd4, 16'sd4096, 16'sd0, 110, 1'b1);
        run_phase(3'd2, 16'sd32767, -16'sd32768, 50, 1'b0);
        run_phase(3'd7, -16'sd100, 16'sd100, 50, 1'b0);
        run_phase(3'd0, -16'sd32768, 16'sd32767, 40, 1'b0);
        run_phase(3'd4, 16'sd2048, -16'sd2048, 50, 1'b0);
        run_phase(3'd3, 16'sd2048, -16'sd2048, 40, 1'b0);
        run_phase(3'd1, 16'sd5000, 16'sd1000, 35, 1'b0);
        run_phase(3'd5, t_sample'($urandom), t_sample'($urandom), 35, 1'b0);
        wait_drained();

        $display("Sent %0d ticks and checked %0d row words across %0d register settings,",
                 board.ticks_taken, board.words_checked, settings_used);
        $display("including clamped row counts, crossed thresholds and a full-scale held row.");
        if (board.mismatches == 0 && board.pending_row_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int        stall;
        bit        calm;
        t_row_word got;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            got.row     = out_bus.row_index;
            got.held[0] = out_bus.held_0;
            got.held[1] = out_bus.held_1;
            got.held[2] = out_bus.held_2;
            got.held[3] = out_bus.held_3;
            got.level   = out_bus.row_level;
            got.active  = out_bus.row_active;
            got.last    = out_bus.last_of_tick;
            board.check_row_word(got);
        end
    end

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
